[src/swpid_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swpid_pkg
// Field widths, operation codes and status codes shared by the stack block,
// its storage and its channel interfaces.
// ----------------------------------------------------------------------------
package swpid_pkg;

   // Payload field widths
   localparam int DATA_W = 32;
   localparam int OP_W   = 2;
   localparam int POS_W  = 8;
   localparam int STAT_W = 2;
   localparam int FILL_W = 8;

   // Operation codes carried in req_type
   localparam logic [OP_W-1:0] OP_PUSH   = 2'd0;
   localparam logic [OP_W-1:0] OP_POP    = 2'd1;
   localparam logic [OP_W-1:0] OP_INSERT = 2'd2;
   localparam logic [OP_W-1:0] OP_DELETE = 2'd3;

   // Status codes returned with each response
   localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
   localparam logic [STAT_W-1:0] ST_EMPTY  = 2'd1;
   localparam logic [STAT_W-1:0] ST_FULL   = 2'd2;
   localparam logic [STAT_W-1:0] ST_BADPOS = 2'd3;

endpackage

[src/swpid_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swpid request and response channels
// Valid/ready channels: one carries requests into the stack, the other
// carries responses out of it.
// ----------------------------------------------------------------------------
interface swpid_req_if;
   logic                                 valid;
   logic                                 ready;
   logic [swpid_pkg::OP_W-1:0]           req_type;
   logic signed [swpid_pkg::DATA_W-1:0]  value;
   logic [swpid_pkg::POS_W-1:0]          position;

   modport source (output valid, output req_type, output value, output position,
                   input ready);
   modport sink   (input valid, input req_type, input value, input position,
                   output ready);
endinterface

interface swpid_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [swpid_pkg::DATA_W-1:0]  read_data;
   logic [swpid_pkg::STAT_W-1:0]         status;
   logic [swpid_pkg::FILL_W-1:0]         fill_count;

   modport source (output valid, output read_data, output status,
                   output fill_count, input ready);
   modport sink   (input valid, input read_data, input status,
                   input fill_count, output ready);
endinterface

[src/swpid_store.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swpid_store
// Entry memory of the stack: one write port and one read port with
// registered read data.
// ----------------------------------------------------------------------------
module swpid_store #(
   parameter int DEPTH = 128,
   parameter int AW    = 7
) (
   input  logic                            clock,
   input  logic                            wr_en,
   input  logic [AW-1:0]                   wr_addr,
   input  logic [swpid_pkg::DATA_W-1:0]    wr_data,
   input  logic [AW-1:0]                   rd_addr,
   output logic [swpid_pkg::DATA_W-1:0]    rd_data
);

   logic [swpid_pkg::DATA_W-1:0] mem [DEPTH];
   logic [swpid_pkg::DATA_W-1:0] rd_data_ff;

   // Write one entry
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Read one entry, data valid the next cycle
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[src/stack_with_positional_insert_delete.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stack_with_positional_insert_delete
// Bounded stack of signed words with insert and delete at a position.
// ----------------------------------------------------------------------------
// Usage:
//   req_ch carries one request (req_type, value, position); rsp_ch returns
//   exactly one response (read_data, status, fill_count) per request.
//   Requests are taken one at a time: req_ch.ready is high only while the
//   block is idle, and drops from acceptance until the response is taken.
//   Push writes the value in S_INS; pop reads the top entry through S_SHIFT
//   and S_DRAIN; delete moves the entries above the position down one place
//   the same way; insert at position k moves the entries from k up one place,
//   then writes the value in S_INS (directly when k equals the entries held).
//   A new request is taken at the earliest in the cycle after its response
//   is taken. The entry memory has one read port and one write port, so one
//   entry moves per cycle: each is read in S_SHIFT and written back in the
//   next. Error responses go straight to S_RESP.
//   The response holds on rsp_ch while rsp_ch.ready is low; no new request
//   is accepted until it is taken.
//   Reset empties the stack at once; no clearing pass runs, since only
//   entries written since reset are ever read.
// ----------------------------------------------------------------------------
module stack_with_positional_insert_delete #(
   parameter int DEPTH = 128
) (
   input  logic       clock,
   input  logic       reset,
   swpid_req_if.sink   req_ch,
   swpid_rsp_if.source rsp_ch
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam int XW = (CW > swpid_pkg::POS_W) ? CW : swpid_pkg::POS_W;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SHIFT,
      S_DRAIN,
      S_INS,
      S_RESP
   } state_type;

   state_type                        state_ff,   state_in;
   logic [swpid_pkg::OP_W-1:0]       op_ff,      op_in;
   logic [swpid_pkg::DATA_W-1:0]     value_ff,   value_in;
   logic [swpid_pkg::DATA_W-1:0]     data_ff,    data_in;
   logic [swpid_pkg::STAT_W-1:0]     status_ff,  status_in;
   logic [CW-1:0]                    count_ff,   count_in;
   logic [AW-1:0]                    ptr_ff,     ptr_in;
   logic [AW-1:0]                    last_ff,    last_in;
   logic [AW-1:0]                    ins_addr_ff, ins_addr_in;
   logic [AW-1:0]                    wdst_ff,    wdst_in;
   logic                             first_ff,   first_in;
   logic                             wpend_ff,   wpend_in;
   logic                             capture_ff, capture_in;

   logic [XW-1:0]                    pos_x;
   logic [XW-1:0]                    cnt_x;
   logic [CW-1:0]                    cnt_m1;
   logic [AW-1:0]                    pos_a;
   logic                             pos_bad;
   logic                             is_full;
   logic                             is_empty;

   logic                             wr_en;
   logic [AW-1:0]                    wr_addr;
   logic [swpid_pkg::DATA_W-1:0]     wr_data;
   logic [swpid_pkg::DATA_W-1:0]     rd_data;

   // Entry memory
   swpid_store #(
      .DEPTH (DEPTH),
      .AW    (AW)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (ptr_ff),
      .rd_data (rd_data)
   );

   // Decode position checks against the current fill
   always_comb begin
      pos_x    = XW'(req_ch.position);
      cnt_x    = XW'(count_ff);
      cnt_m1   = count_ff - CW'(1);
      pos_a    = pos_x[AW-1:0];
      pos_bad  = (pos_x == '0) || (pos_x > cnt_x);
      is_full  = (count_ff == CW'(DEPTH));
      is_empty = (count_ff == '0);
   end

   // Write port: moved entry first, otherwise the new value
   always_comb begin
      wr_en   = wpend_ff || (state_ff == S_INS);
      wr_addr = wpend_ff ? wdst_ff : ins_addr_ff;
      wr_data = wpend_ff ? rd_data : value_ff;
   end

   // Sequencer next state
   always_comb begin
      state_in    = state_ff;
      op_in       = op_ff;
      value_in    = value_ff;
      data_in     = data_ff;
      status_in   = status_ff;
      count_in    = count_ff;
      ptr_in      = ptr_ff;
      last_in     = last_ff;
      ins_addr_in = ins_addr_ff;
      wdst_in     = wdst_ff;
      first_in    = first_ff;
      wpend_in    = 1'b0;
      capture_in  = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (req_ch.valid) begin
               op_in     = req_ch.req_type;
               value_in  = req_ch.value;
               data_in   = '0;
               status_in = swpid_pkg::ST_OK;
               first_in  = 1'b1;
               case (req_ch.req_type)
                  swpid_pkg::OP_PUSH: begin
                     if (is_full) begin
                        status_in = swpid_pkg::ST_FULL;
                        state_in  = S_RESP;
                     end else begin
                        ins_addr_in = count_ff[AW-1:0];
                        count_in    = count_ff + CW'(1);
                        state_in    = S_INS;
                     end
                  end
                  swpid_pkg::OP_POP: begin
                     if (is_empty) begin
                        status_in = swpid_pkg::ST_EMPTY;
                        state_in  = S_RESP;
                     end else begin
                        ptr_in   = cnt_m1[AW-1:0];
                        last_in  = cnt_m1[AW-1:0];
                        count_in = cnt_m1;
                        state_in = S_SHIFT;
                     end
                  end
                  swpid_pkg::OP_INSERT: begin
                     if (pos_bad) begin
                        status_in = swpid_pkg::ST_BADPOS;
                        state_in  = S_RESP;
                     end else if (is_full) begin
                        status_in = swpid_pkg::ST_FULL;
                        state_in  = S_RESP;
                     end else begin
                        count_in    = count_ff + CW'(1);
                        ins_addr_in = pos_a;
                        ptr_in      = cnt_m1[AW-1:0];
                        last_in     = pos_a;
                        state_in    = (pos_x == cnt_x) ? S_INS : S_SHIFT;
                     end
                  end
                  default: begin
                     if (pos_bad) begin
                        status_in = swpid_pkg::ST_BADPOS;
                        state_in  = S_RESP;
                     end else begin
                        ptr_in   = pos_a - AW'(1);
                        last_in  = cnt_m1[AW-1:0];
                        count_in = cnt_m1;
                        state_in = S_SHIFT;
                     end
                  end
               endcase
            end
         end

         // Move one entry per cycle: read here, write back next cycle
         S_SHIFT: begin
            first_in = 1'b0;
            if (op_ff == swpid_pkg::OP_INSERT) begin
               wpend_in = 1'b1;
               wdst_in  = ptr_ff + AW'(1);
            end else begin
               capture_in = first_ff;
               wpend_in   = !first_ff;
               wdst_in    = ptr_ff - AW'(1);
            end
            if (ptr_ff == last_ff) begin
               state_in = S_DRAIN;
            end else if (op_ff == swpid_pkg::OP_INSERT) begin
               ptr_in = ptr_ff - AW'(1);
            end else begin
               ptr_in = ptr_ff + AW'(1);
            end
         end

         // Finish the last pending write
         S_DRAIN: begin
            state_in = (op_ff == swpid_pkg::OP_INSERT) ? S_INS : S_RESP;
         end

         S_INS: begin
            state_in = S_RESP;
         end

         S_RESP: begin
            if (rsp_ch.ready) begin
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase

      // Capture the word being popped or deleted
      if (capture_ff) begin
         data_in = rd_data;
      end
   end

   // Hold state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         count_ff   <= '0;
         first_ff   <= 1'b0;
         wpend_ff   <= 1'b0;
         capture_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         count_ff   <= count_in;
         first_ff   <= first_in;
         wpend_ff   <= wpend_in;
         capture_ff <= capture_in;
      end
      op_ff       <= op_in;
      value_ff    <= value_in;
      data_ff     <= data_in;
      status_ff   <= status_in;
      ptr_ff      <= ptr_in;
      last_ff     <= last_in;
      ins_addr_ff <= ins_addr_in;
      wdst_ff     <= wdst_in;
   end

   // Drive the channels
   assign req_ch.ready       = (state_ff == S_IDLE);
   assign rsp_ch.valid       = (state_ff == S_RESP);
   assign rsp_ch.read_data   = data_ff;
   assign rsp_ch.status      = status_ff;
   assign rsp_ch.fill_count  = swpid_pkg::FILL_W'(count_ff);

endmodule

[dv/stack_response_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stack_response_checker
// Watches the request and response channels of the positional stack, keeps
// its own copy of the stack contents, works out the response each accepted
// request must produce and compares every returned response field by field.
// ----------------------------------------------------------------------------
module stack_response_checker #(
   parameter int DEPTH = 128
) (
   input  logic        clock,
   input  logic        reset,
   swpid_req_if        req_ch,
   swpid_rsp_if        rsp_ch,
   output int unsigned held_count,
   output int unsigned pending_count,
   output int unsigned fail_count
);

   typedef struct packed {
      logic signed [swpid_pkg::DATA_W-1:0] read_data;
      logic [swpid_pkg::STAT_W-1:0]        status;
      logic [swpid_pkg::FILL_W-1:0]        fill_count;
   } stack_rsp_type;

   // Shadow copy of the stack and the responses still owed by the block
   logic signed [swpid_pkg::DATA_W-1:0] shadow_entries [DEPTH];
   int unsigned                         shadow_total = 0;
   stack_rsp_type                       owed_responses [$];
   int unsigned                         fail_total = 0;

   // Apply one request to the shadow stack and return the response it owes
   function automatic stack_rsp_type apply_stack_op(
      input logic [swpid_pkg::OP_W-1:0]          op,
      input logic signed [swpid_pkg::DATA_W-1:0] val,
      input logic [swpid_pkg::POS_W-1:0]         pos);
      stack_rsp_type rsp;
      int unsigned   k;
      rsp.read_data = '0;
      rsp.status    = swpid_pkg::ST_OK;
      case (op)
         swpid_pkg::OP_PUSH: begin
            if (shadow_total >= DEPTH) begin
               rsp.status = swpid_pkg::ST_FULL;
            end else begin
               shadow_entries[shadow_total] = val;
               shadow_total++;
            end
         end
         swpid_pkg::OP_POP: begin
            if (shadow_total == 0) begin
               rsp.status = swpid_pkg::ST_EMPTY;
            end else begin
               shadow_total--;
               rsp.read_data = shadow_entries[shadow_total];
            end
         end
         swpid_pkg::OP_INSERT: begin
            // bad position takes priority over a full stack
            if (pos < 1 || pos > shadow_total) begin
               rsp.status = swpid_pkg::ST_BADPOS;
            end else if (shadow_total >= DEPTH) begin
               rsp.status = swpid_pkg::ST_FULL;
            end else begin
               for (k = shadow_total; k > pos; k--)
                  shadow_entries[k] = shadow_entries[k-1];
               shadow_entries[pos] = val;
               shadow_total++;
            end
         end
         default: begin
            if (pos < 1 || pos > shadow_total) begin
               rsp.status = swpid_pkg::ST_BADPOS;
            end else begin
               rsp.read_data = shadow_entries[pos-1];
               for (k = pos - 1; k + 1 < shadow_total; k++)
                  shadow_entries[k] = shadow_entries[k+1];
               shadow_total--;
            end
         end
      endcase
      rsp.fill_count = shadow_total[swpid_pkg::FILL_W-1:0];
      return rsp;
   endfunction

   // Report a mismatch and count it
   task automatic flag_mismatch(input string                        field,
                                input logic [swpid_pkg::DATA_W-1:0] want,
                                input logic [swpid_pkg::DATA_W-1:0] got);
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, want, got);
      fail_total++;
   endtask

   // Predict on each accepted request, compare on each accepted response
   always @(posedge clock) begin : watch_channels
      stack_rsp_type got;
      stack_rsp_type want;
      if (reset) begin
         shadow_total = 0;
         owed_responses.delete();
      end else begin
         if (req_ch.valid && req_ch.ready)
            owed_responses.push_back(apply_stack_op(req_ch.req_type, req_ch.value,
                                                    req_ch.position));
         if (rsp_ch.valid && rsp_ch.ready) begin
            got.read_data  = rsp_ch.read_data;
            got.status     = rsp_ch.status;
            got.fill_count = rsp_ch.fill_count;
            if (owed_responses.size() == 0) begin
               flag_mismatch("unrequested response", '0, got.read_data);
            end else begin
               want = owed_responses.pop_front();
               if (got.read_data !== want.read_data)
                  flag_mismatch("read_data", want.read_data, got.read_data);
               if (got.status !== want.status)
                  flag_mismatch("status", swpid_pkg::DATA_W'(want.status),
                                swpid_pkg::DATA_W'(got.status));
               if (got.fill_count !== want.fill_count)
                  flag_mismatch("fill_count", swpid_pkg::DATA_W'(want.fill_count),
                                swpid_pkg::DATA_W'(got.fill_count));
            end
         end
      end
      held_count    <= shadow_total;
      pending_count <= owed_responses.size();
      fail_count    <= fail_total;
   end

endmodule

[dv/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives the positional stack with a directed opening (empty, full and bad
// position cases, every operation, extreme words) and then random phases that
// grow, shrink or churn the stack, with random idling on both channels.
// ----------------------------------------------------------------------------
module testbench;

   localparam int DEPTH           = 128;
   localparam int RANDOM_REQUESTS = 1740;
   localparam int CYCLE_LIMIT     = 2_000_000;

   typedef enum int {FILL_UP, DRAIN_DOWN, CHURN} op_mix_type;

   logic        clock;
   logic        reset;
   int unsigned held_count;
   int unsigned pending_count;
   int unsigned fail_count;
   int unsigned cycle_count;
   bit          calm_sender;

   swpid_req_if req_ch ();
   swpid_rsp_if rsp_ch ();

   stack_with_positional_insert_delete #(.DEPTH(DEPTH)) dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   stack_response_checker #(.DEPTH(DEPTH)) rsp_check (
      .clock         (clock),
      .reset         (reset),
      .req_ch        (req_ch),
      .rsp_ch        (rsp_ch),
      .held_count    (held_count),
      .pending_count (pending_count),
      .fail_count    (fail_count)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   // Bound the run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("%0t: cycle limit reached", $time);
         $display("testbench failed");
         $finish;
      end
   end

   // Idle length: mostly none or short, now and then long
   function automatic int unsigned idle_cycles();
      int unsigned roll;
      roll = $urandom_range(99);
      if (roll < 55)
         return 0;
      if (roll < 92)
         return $urandom_range(3, 1);
      return $urandom_range(60, 12);
   endfunction

   function automatic logic [swpid_pkg::OP_W-1:0] pick_operation(input op_mix_type mix);
      int unsigned roll;
      roll = $urandom_range(99);
      case (mix)
         FILL_UP: begin
            if (roll < 45) return swpid_pkg::OP_PUSH;
            if (roll < 90) return swpid_pkg::OP_INSERT;
            if (roll < 95) return swpid_pkg::OP_POP;
            return swpid_pkg::OP_DELETE;
         end
         DRAIN_DOWN: begin
            if (roll < 45) return swpid_pkg::OP_POP;
            if (roll < 90) return swpid_pkg::OP_DELETE;
            if (roll < 95) return swpid_pkg::OP_PUSH;
            return swpid_pkg::OP_INSERT;
         end
         default: begin
            if (roll < 25) return swpid_pkg::OP_PUSH;
            if (roll < 50) return swpid_pkg::OP_POP;
            if (roll < 75) return swpid_pkg::OP_INSERT;
            return swpid_pkg::OP_DELETE;
         end
      endcase
   endfunction

   // Mostly held positions, some at the top, some out of range
   function automatic logic [swpid_pkg::POS_W-1:0] pick_position();
      int unsigned roll;
      roll = $urandom_range(99);
      if (roll < 8)
         return '0;
      if (roll < 16)
         return swpid_pkg::POS_W'($urandom_range(255, held_count + 1));
      if (roll < 30)
         return swpid_pkg::POS_W'(held_count);
      return swpid_pkg::POS_W'($urandom_range(held_count > 0 ? held_count : 1, 1));
   endfunction

   function automatic logic signed [swpid_pkg::DATA_W-1:0] pick_word();
      int unsigned roll;
      roll = $urandom_range(99);
      if (roll < 3)  return 32'sh7FFF_FFFF;
      if (roll < 6)  return 32'sh8000_0000;
      if (roll < 9)  return '0;
      if (roll < 12) return '1;
      return $urandom;
   endfunction

   // Present one request and hold it until accepted; valid stays high after
   task automatic send_request(input logic [swpid_pkg::OP_W-1:0]          op,
                               input logic signed [swpid_pkg::DATA_W-1:0] val,
                               input logic [swpid_pkg::POS_W-1:0]         pos);
      int unsigned gap;
      gap = calm_sender ? 0 : idle_cycles();
      if (gap != 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid    <= 1'b1;
      req_ch.req_type <= op;
      req_ch.value    <= val;
      req_ch.position <= pos;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
   endtask

   // Hold off the sender until every owed response has returned
   task automatic wait_for_responses();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
   endtask

   // Response side: random stalls, with calm stretches
   initial begin : response_side
      int unsigned stall_left;
      int unsigned calm_left;
      bit          calm;
      stall_left = 0;
      calm_left  = 0;
      calm       = 1'b0;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (calm_left == 0) begin
            calm      = ($urandom_range(3) == 0);
            calm_left = $urandom_range(400, 50);
         end
         calm_left--;
         if (stall_left != 0) begin
            rsp_ch.ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_ch.ready <= 1'b1;
            if (!calm && $urandom_range(2) == 0)
               stall_left = idle_cycles();
         end
      end
   end

   // Request side
   initial begin : request_side
      int unsigned                 issued;
      int unsigned                 span;
      op_mix_type                  mix;
      logic [swpid_pkg::OP_W-1:0]  op;
      calm_sender     = 1'b0;
      reset           <= 1'b1;
      req_ch.valid    <= 1'b0;
      req_ch.req_type <= swpid_pkg::OP_PUSH;
      req_ch.value    <= '0;
      req_ch.position <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Empty stack: pop and every position reject
      send_request(swpid_pkg::OP_POP,    '0, 8'd0);
      send_request(swpid_pkg::OP_DELETE, '0, 8'd1);
      send_request(swpid_pkg::OP_INSERT, 32'sd7, 8'd0);
      send_request(swpid_pkg::OP_INSERT, 32'sd7, 8'd1);
      // Extreme words
      send_request(swpid_pkg::OP_PUSH, 32'sh7FFF_FFFF, 8'd0);
      send_request(swpid_pkg::OP_PUSH, 32'sh8000_0000, 8'd255);
      send_request(swpid_pkg::OP_PUSH, '0, 8'd0);
      send_request(swpid_pkg::OP_PUSH, '1, 8'd0);
      // Insert: below range, above range, at the top, at the bottom
      send_request(swpid_pkg::OP_INSERT, 32'sd11, 8'd0);
      send_request(swpid_pkg::OP_INSERT, 32'sd12, 8'd5);
      send_request(swpid_pkg::OP_INSERT, 32'sh5A5A_5A5A, 8'd4);
      send_request(swpid_pkg::OP_INSERT, 32'shA5A5_A5A5, 8'd1);
      // Delete: bad positions, top, bottom
      send_request(swpid_pkg::OP_DELETE, '1, 8'd0);
      send_request(swpid_pkg::OP_DELETE, '0, 8'd255);
      send_request(swpid_pkg::OP_DELETE, '0, 8'd128);
      send_request(swpid_pkg::OP_DELETE, '0, 8'd6);
      send_request(swpid_pkg::OP_DELETE, '0, 8'd1);
      send_request(swpid_pkg::OP_INSERT, 32'sd123, 8'd2);
      // Drain and pop past empty
      repeat (6) send_request(swpid_pkg::OP_POP, '1, 8'd0);
      send_request(swpid_pkg::OP_DELETE, '0, 8'd0);
      wait_for_responses();

      // Fill to the limit, then push and insert against a full stack
      calm_sender = 1'b1;
      while (held_count < DEPTH)
         send_request(swpid_pkg::OP_PUSH, pick_word(), 8'd0);
      calm_sender = 1'b0;
      send_request(swpid_pkg::OP_PUSH, pick_word(), 8'd0);
      send_request(swpid_pkg::OP_INSERT, pick_word(),
                   swpid_pkg::POS_W'($urandom_range(DEPTH, 1)));
      send_request(swpid_pkg::OP_INSERT, pick_word(), 8'd0);
      send_request(swpid_pkg::OP_INSERT, pick_word(), 8'd200);
      send_request(swpid_pkg::OP_DELETE, '0, swpid_pkg::POS_W'(DEPTH));
      wait_for_responses();

      // Random phases biased to grow, shrink or churn the stack
      issued = 0;
      while (issued < RANDOM_REQUESTS) begin
         case ($urandom_range(2))
            0:       mix = FILL_UP;
            1:       mix = DRAIN_DOWN;
            default: mix = CHURN;
         endcase
         calm_sender = ($urandom_range(3) == 0);
         span        = $urandom_range(250, 40);
         if (span > RANDOM_REQUESTS - issued)
            span = RANDOM_REQUESTS - issued;
         repeat (span) begin
            op = pick_operation(mix);
            send_request(op, pick_word(), pick_position());
            issued++;
         end
         if ($urandom_range(3) == 0)
            wait_for_responses();
      end

      // Let the last response drain, then give the verdict
      wait_for_responses();
      repeat (DEPTH + 16) @(posedge clock);
      if (fail_count == 0)
         $display("testbench passed");
      else
         $display("testbench failed");
      $finish;
   end

endmodule
